// ===== rtl/sdx_pkg.sv =====
// Shared types and constants for the SLIP deframer with XOR check.
// Used by sdx_frame_core and slip_deframer_xor_check_unit; no dependencies.
package sdx_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 12;
  localparam int KIND_W  = 2;

  // Result queue depth; must be at least 2 since one byte can cause two results.
  localparam int RES_DEPTH = 4;

  localparam logic [BYTE_W-1:0] SLIP_END     = 8'hC0;
  localparam logic [BYTE_W-1:0] SLIP_ESC     = 8'hDB;
  localparam logic [BYTE_W-1:0] SLIP_ESC_END = 8'hDC;
  localparam logic [BYTE_W-1:0] SLIP_ESC_ESC = 8'hDD;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 12'd1000;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_DROP = 2'd2
  } sdx_kind_e;

  typedef struct packed {
    sdx_kind_e         kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  len;
    logic              last;
  } sdx_res_t;

  // Results caused by one input beat: count 0..2, first in r0.
  typedef struct packed {
    logic [1:0] n;
    sdx_res_t   r0;
    sdx_res_t   r1;
  } sdx_step_t;

endpackage

// ===== rtl/sdx_frame_core.sv =====
// Frame state, un-escaping and checksum logic of the SLIP deframer.
// Depends on sdx_pkg; produces up to two results per accepted byte.
module sdx_frame_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [sdx_pkg::LEN_W-1:0]  cfg_wdata,
  input  logic                       step,
  input  logic [sdx_pkg::BYTE_W-1:0] in_byte,
  output sdx_pkg::sdx_step_t         res
);
  import sdx_pkg::*;

  logic [LEN_W-1:0]  overflow_limit;
  logic [LEN_W-1:0]  raw_count,      raw_count_next;
  logic [BYTE_W-1:0] checksum_accum, checksum_accum_next;
  logic [BYTE_W-1:0] prev_byte_one,  prev_byte_one_next;
  logic [BYTE_W-1:0] prev_byte_two,  prev_byte_two_next;
  logic              escape_pending, escape_pending_next;

  logic [LEN_W:0]    cnt;
  logic [LEN_W-1:0]  cnt_sat;
  logic [BYTE_W-1:0] want;
  logic              sum_ok;

  function automatic sdx_res_t mk_res(sdx_kind_e k, logic [BYTE_W-1:0] b,
                                      logic [LEN_W-1:0] l);
    sdx_res_t r;
    r.kind      = k;
    r.data_byte = b;
    r.len       = l;
    r.last      = 1'b0;
    return r;
  endfunction

  assign cnt     = {1'b0, raw_count} + {{LEN_W{1'b0}}, 1'b1};
  assign cnt_sat = cnt[LEN_W] ? {LEN_W{1'b1}} : cnt[LEN_W-1:0];
  // Expected check value: (second-last << 4) + last, modulo 256.
  assign want    = {prev_byte_two[3:0], 4'b0000} + prev_byte_one;
  assign sum_ok  = (raw_count > LEN_W'(2)) && (checksum_accum == want);

  always_comb begin
    res                 = '0;
    raw_count_next      = raw_count;
    checksum_accum_next = checksum_accum;
    prev_byte_one_next  = prev_byte_one;
    prev_byte_two_next  = prev_byte_two;
    escape_pending_next = escape_pending;

    if (in_byte == SLIP_END) begin
      if (raw_count != '0) begin
        if (escape_pending) begin
          res.r0 = mk_res(KIND_DATA, SLIP_ESC, '0);
          res.r1 = mk_res(sum_ok ? KIND_END : KIND_DROP, '0, raw_count);
          res.n  = 2'd2;
        end else begin
          res.r0 = mk_res(sum_ok ? KIND_END : KIND_DROP, '0, raw_count);
          res.n  = 2'd1;
        end
      end
      raw_count_next      = '0;
      checksum_accum_next = '0;
      prev_byte_one_next  = '0;
      prev_byte_two_next  = '0;
      escape_pending_next = 1'b0;
    end else if (cnt > {1'b0, overflow_limit}) begin
      res.r0              = mk_res(KIND_DROP, '0, cnt_sat);
      res.n               = 2'd1;
      raw_count_next      = '0;
      checksum_accum_next = '0;
      prev_byte_one_next  = '0;
      prev_byte_two_next  = '0;
      escape_pending_next = 1'b0;
    end else begin
      // The XOR lags two bytes behind so the trailing check bytes stay out.
      if (raw_count[LEN_W-1:1] != '0) begin
        checksum_accum_next = checksum_accum ^ prev_byte_two;
      end
      prev_byte_two_next = prev_byte_one;
      prev_byte_one_next = in_byte;
      raw_count_next     = cnt[LEN_W-1:0];

      if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (in_byte == SLIP_ESC_END) begin
          res.r0 = mk_res(KIND_DATA, SLIP_END, '0);
          res.n  = 2'd1;
        end else if (in_byte == SLIP_ESC_ESC) begin
          res.r0 = mk_res(KIND_DATA, SLIP_ESC, '0);
          res.n  = 2'd1;
        end else if (in_byte == SLIP_ESC) begin
          res.r0              = mk_res(KIND_DATA, SLIP_ESC, '0);
          res.n               = 2'd1;
          escape_pending_next = 1'b1;
        end else begin
          res.r0 = mk_res(KIND_DATA, SLIP_ESC, '0);
          res.r1 = mk_res(KIND_DATA, in_byte, '0);
          res.n  = 2'd2;
        end
      end else if (in_byte == SLIP_ESC) begin
        escape_pending_next = 1'b1;
      end else begin
        res.r0 = mk_res(KIND_DATA, in_byte, '0);
        res.n  = 2'd1;
      end
    end

    res.r0.last = (res.n == 2'd1);
    res.r1.last = (res.n == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_limit <= LIMIT_RESET;
      raw_count      <= '0;
      checksum_accum <= '0;
      prev_byte_one  <= '0;
      prev_byte_two  <= '0;
      escape_pending <= 1'b0;
    end else begin
      if (cfg_wen) begin
        overflow_limit <= cfg_wdata;
      end
      if (step) begin
        raw_count      <= raw_count_next;
        checksum_accum <= checksum_accum_next;
        prev_byte_one  <= prev_byte_one_next;
        prev_byte_two  <= prev_byte_two_next;
        escape_pending <= escape_pending_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_overflow_clears: assert property (@(posedge clk) disable iff (rst)
    step && in_byte != SLIP_END && cnt > {1'b0, overflow_limit} |=> raw_count == '0)
    else $error("overflow did not restart the frame");

  a_esc_needs_bytes: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> raw_count != '0)
    else $error("escape pending with empty frame");

  a_delim_clears: assert property (@(posedge clk) disable iff (rst)
    step && in_byte == SLIP_END |=> raw_count == '0 && !escape_pending)
    else $error("delimiter did not clear frame state");
`endif

endmodule

// ===== rtl/slip_deframer_xor_check_unit.sv =====
// Results are registered: each result is written into the result queue and presented from its head.
// Throughput: one input beat per cycle while each byte yields at most one result and
// m_axis_tready stays high; a byte that yields two results puts an extra beat on the output,
// absorbed by the result queue of ResDepth entries that sets when s_axis_tready drops.
// Reset (rst, synchronous): frame state cleared, queue emptied, overflow limit 1000.
// Top level of the SLIP deframer; depends on sdx_pkg and sdx_frame_core.
module slip_deframer_xor_check_unit #(
  parameter int ResDepth = sdx_pkg::RES_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [sdx_pkg::LEN_W-1:0] cfg_wdata,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] in_byte
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,   // [7:0] out_byte, [19:8] raw_length
  output logic [1:0]                m_axis_tuser,   // [1:0] out_kind
  output logic                      m_axis_tlast    // last
);
  import sdx_pkg::*;

  localparam int PtrW = (ResDepth > 1) ? $clog2(ResDepth) : 1;
  localparam int CntW = $clog2(ResDepth + 1);

  sdx_step_t         step_res;
  logic              in_beat;
  logic              out_beat;
  sdx_res_t          queue [ResDepth];
  logic [PtrW-1:0]   wr_ptr, wr_ptr_next, wr_ptr_1;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count, count_next;
  sdx_res_t          head;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(ResDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  sdx_frame_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .step      (in_beat),
    .in_byte   (s_axis_tdata[BYTE_W-1:0]),
    .res       (step_res)
  );

  // Room for two results is kept so any accepted byte fits.
  assign s_axis_tready = (count <= CntW'(ResDepth - 2));
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count != '0);
  assign out_beat      = m_axis_tvalid && m_axis_tready;

  assign head          = queue[rd_ptr];
  assign m_axis_tdata  = {4'b0000, head.len, head.data_byte};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  assign wr_ptr_1 = ptr_inc(wr_ptr);

  always_comb begin
    wr_ptr_next = wr_ptr;
    count_next  = count - CntW'(out_beat);
    if (in_beat) begin
      if (step_res.n == 2'd1) begin
        wr_ptr_next = wr_ptr_1;
      end else if (step_res.n == 2'd2) begin
        wr_ptr_next = ptr_inc(wr_ptr_1);
      end
      count_next = count_next + CntW'(step_res.n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (out_beat) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && step_res.n != 2'd0) begin
      queue[wr_ptr] <= step_res.r0;
    end
    if (in_beat && step_res.n == 2'd2) begin
      queue[wr_ptr_1] <= step_res.r1;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(ResDepth))
    else $error("result queue overfilled");

  a_data_no_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_DATA |-> m_axis_tdata[19:8] == '0)
    else $error("data beat carries a frame length");

  a_end_no_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata[7:0] == '0 && m_axis_tlast)
    else $error("frame end beat malformed");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !in_beat && !out_beat |=> $stable(count))
    else $error("queue count moved without a beat");
`endif

endmodule
